// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

   // Fixed field widths of the channels and the register.
   localparam int SLOT_W    = 3;
   localparam int PAGE_W    = 16;
   localparam int COUNT_W   = 16;
   localparam int CFG_W     = 4;
   localparam int CFG_RESET = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One result item as it sits in the output or skid register.
   typedef struct packed {
      logic               fault;
      logic [SLOT_W-1:0]  frame_slot;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [COUNT_W-1:0] fault_count;
      logic               done_res;
   } rsp_type;

   // Update command broadcast from the top level to every frame cell.
   typedef struct packed {
      logic upd;   // a reference is taken this cycle
      logic clr;   // empty all frames at the end of this cycle
      logic hit;   // the reference hit in some cell
   } cell_ctl_type;

   // Match flags that ripple along the row of cells.
   typedef struct packed {
      logic hit;     // some earlier cell holds the page
      logic victim;  // some earlier cell is the least recently used one
   } chain_flags_type;

endpackage

// ===== rtl/lpr_cell.sv =====
module lpr_cell #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16,
   parameter int IDX       = 0,
   parameter int RW        = 3,
   parameter int NW        = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lpr_pkg::cell_ctl_type    ctl,
   input  logic [PAGE_BITS-1:0]     page,
   input  logic [NW-1:0]            frames_n,
   input  logic [RW-1:0]            last_rank,
   input  logic [RW-1:0]            hit_rank,
   input  logic                     prev_valid,
   output logic                     valid,
   input  lpr_pkg::chain_flags_type flags_i,
   input  logic [RW-1:0]            rank_i,
   input  logic [RW-1:0]            hit_slot_i,
   input  logic [RW-1:0]            miss_slot_i,
   input  logic [PAGE_BITS-1:0]     victim_page_i,
   output lpr_pkg::chain_flags_type flags_o,
   output logic [RW-1:0]            rank_o,
   output logic [RW-1:0]            hit_slot_o,
   output logic [RW-1:0]            miss_slot_o,
   output logic [PAGE_BITS-1:0]     victim_page_o
);
   import lpr_pkg::*;

   logic                 valid_ff, valid_in;
   logic [RW-1:0]        rank_ff, rank_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 managed;
   logic                 hit_here;
   logic                 empty_here;
   logic                 victim_here;

   assign valid = valid_ff;

   // Local role of this frame for the reference on the request port.
   // Filled frames always form a prefix, so the first empty frame is the
   // one whose left neighbor is filled.
   always_comb begin
      managed     = NW'(IDX) < frames_n;
      hit_here    = valid_ff && (page_ff == page);
      empty_here  = managed && !valid_ff && prev_valid;
      victim_here = valid_ff && (rank_ff == last_rank);
   end

   // Merge this frame's findings into the chain.
   always_comb begin
      flags_o.hit    = flags_i.hit | hit_here;
      flags_o.victim = flags_i.victim | victim_here;
      rank_o         = rank_i | (hit_here ? rank_ff : '0);
      hit_slot_o     = hit_slot_i | (hit_here ? RW'(IDX) : '0);
      miss_slot_o    = miss_slot_i | ((empty_here || victim_here) ? RW'(IDX) : '0);
      victim_page_o  = victim_page_i | (victim_here ? page_ff : '0);
   end

   // Next state of the frame.
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      page_in  = page_ff;
      priority if (ctl.clr) begin
         valid_in = 1'b0;
         rank_in  = '0;
      end else if (ctl.upd && ctl.hit) begin
         if (hit_here) begin
            rank_in = '0;
         end else if (valid_ff && (rank_ff < hit_rank)) begin
            rank_in = rank_ff + RW'(1);
         end
      end else if (ctl.upd) begin
         if (empty_here || victim_here) begin
            page_in  = page;
            valid_in = 1'b1;
            rank_in  = '0;
         end else if (valid_ff) begin
            rank_in = rank_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   // Page contents are only read while the frame is valid.
   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement unit.
//
// Request channel (req_): one page reference per transfer, with a last flag
// that closes a sequence. Response channel (rsp_): one result per reference,
// giving hit or fault, the frame that now holds the page, the evicted page
// if any, the saturating fault count and an echo of the last flag.
// Each frame is a cell in a row; match, rank and victim information ripples
// along the row so a whole reference is decided combinationally.
// The result of a reference is registered in the output register, or in the
// skid register while rsp_ is stalled. One reference per cycle is sustained while rsp_stall is low.
// A two-entry output stage (output register plus skid register) lets the
// block take one more reference while a result is stalled; req_stall rises
// only once both entries hold results, and results are never dropped.
// Reset empties all frames, clears the fault count and sets the managed frame
// count to 3. A write on csr_ sets the managed frame count (0 acts as 1,
// values above FRAMES act as FRAMES) and also starts a new sequence.
// After a reference marked last, frames and count are cleared.
module lru_page_replacement #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lpr_pkg::PAGE_W-1:0]  req_page,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_fault,
   output logic [lpr_pkg::SLOT_W-1:0]  rsp_frame_slot,
   output logic                        rsp_evicted_valid,
   output logic [lpr_pkg::PAGE_W-1:0]  rsp_evicted_page,
   output logic [lpr_pkg::COUNT_W-1:0] rsp_fault_count,
   output logic                        rsp_done_res,
   input  logic                        csr_wr_en,
   input  logic [lpr_pkg::CFG_W-1:0]   csr_wr_data
);
   import lpr_pkg::*;

   localparam int RW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int NW     = $clog2(FRAMES + 1);
   localparam int NRESET = (CFG_RESET > FRAMES) ? FRAMES : CFG_RESET;

   logic                 accept;
   logic [PAGE_BITS-1:0] page;
   logic [NW-1:0]        n_ff, n_in, n_wr;
   logic [RW-1:0]        last_rank;
   logic [COUNT_W-1:0]   count_ff, count_in, count_res;
   cell_ctl_type         ctl;
   logic [FRAMES-1:0]    valid_vec;
   rsp_type              res;
   rsp_type              rsp_ff, rsp_in;
   rsp_type              skid_ff, skid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic                 out_adv;
   logic                 ev_valid;

   chain_flags_type      flags   [FRAMES+1];
   logic [RW-1:0]        rank_c  [FRAMES+1];
   logic [RW-1:0]        hslot_c [FRAMES+1];
   logic [RW-1:0]        mslot_c [FRAMES+1];
   logic [PAGE_BITS-1:0] vpage_c [FRAMES+1];

   // Request transfer; the skid register being full holds off new work.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign page      = PAGE_BITS'(req_page);

   // Managed frame count, clamped when written.
   always_comb begin
      if (csr_wr_data == '0) begin
         n_wr = NW'(1);
      end else if (int'(csr_wr_data) > FRAMES) begin
         n_wr = NW'(FRAMES);
      end else begin
         n_wr = NW'(csr_wr_data);
      end
      n_in      = csr_wr_en ? n_wr : n_ff;
      last_rank = RW'(n_ff - NW'(1));
   end

   // Command broadcast to the frame cells.
   always_comb begin
      ctl.upd = accept;
      ctl.clr = csr_wr_en || (accept && req_last);
      ctl.hit = flags[FRAMES].hit;
   end

   // Row of frame cells; cell 0 sees an empty chain and a filled neighbor.
   assign flags[0]   = '0;
   assign rank_c[0]  = '0;
   assign hslot_c[0] = '0;
   assign mslot_c[0] = '0;
   assign vpage_c[0] = '0;

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = valid_vec[i-1];
      end
      lpr_cell #(
         .FRAMES    (FRAMES),
         .PAGE_BITS (PAGE_BITS),
         .IDX       (i),
         .RW        (RW),
         .NW        (NW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .page          (page),
         .frames_n      (n_ff),
         .last_rank     (last_rank),
         .hit_rank      (rank_c[FRAMES]),
         .prev_valid    (prev_valid),
         .valid         (valid_vec[i]),
         .flags_i       (flags[i]),
         .rank_i        (rank_c[i]),
         .hit_slot_i    (hslot_c[i]),
         .miss_slot_i   (mslot_c[i]),
         .victim_page_i (vpage_c[i]),
         .flags_o       (flags[i+1]),
         .rank_o        (rank_c[i+1]),
         .hit_slot_o    (hslot_c[i+1]),
         .miss_slot_o   (mslot_c[i+1]),
         .victim_page_o (vpage_c[i+1])
      );
   end

   // Result of the reference and the saturating fault count.
   always_comb begin
      ev_valid = !flags[FRAMES].hit && flags[FRAMES].victim;
      if (flags[FRAMES].hit || (count_ff == COUNT_MAX)) begin
         count_res = count_ff;
      end else begin
         count_res = count_ff + COUNT_W'(1);
      end
      res.fault         = !flags[FRAMES].hit;
      res.frame_slot    = flags[FRAMES].hit ? SLOT_W'(hslot_c[FRAMES])
                                            : SLOT_W'(mslot_c[FRAMES]);
      res.evicted_valid = ev_valid;
      res.evicted_page  = ev_valid ? PAGE_W'(vpage_c[FRAMES]) : '0;
      res.fault_count   = count_res;
      res.done_res      = req_last;

      count_in = count_ff;
      if (csr_wr_en || (accept && req_last)) begin
         count_in = '0;
      end else if (accept) begin
         count_in = count_res;
      end
   end

   // Output register with skid: the skid entry is filled only when a result
   // is produced while the output register is stalled.
   always_comb begin
      out_adv       = !rsp_valid_ff || !rsp_stall;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_adv) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = res;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff          <= NW'(NRESET);
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         n_ff          <= n_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = rsp_ff.fault;
   assign rsp_frame_slot    = rsp_ff.frame_slot;
   assign rsp_evicted_valid = rsp_ff.evicted_valid;
   assign rsp_evicted_page  = rsp_ff.evicted_page;
   assign rsp_fault_count   = rsp_ff.fault_count;
   assign rsp_done_res      = rsp_ff.done_res;

   // Filled frames always form a contiguous run starting at frame 0.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + FRAMES'(1)) & valid_vec) == '0)
      else $error("filled frames are not a prefix");

   // Never more filled frames than are managed.
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) <= int'(n_ff))
      else $error("more frames filled than managed");

   // The skid entry only holds a result behind a waiting output register.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full with output register empty");

   // An eviction only happens on a fault.
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      (accept && ev_valid) |=> (rsp_valid_ff && (rsp_ff.fault || skid_ff.fault)))
      else $error("eviction reported without a fault");

endmodule

// ===== bench/lru_page_replacement_test.sv =====
module lru_page_replacement_test;
   import lpr_pkg::*;

   localparam int FRAMES       = 8;
   localparam int RANDOM_REFS  = 1800;
   localparam int PHASES       = 8;
   localparam int HOLD_CYCLES  = 40;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic {ROW_REF, ROW_CFG} row_kind_type;

   // One line of the directed table: a reference or a frame count write.
   typedef struct {
      row_kind_type      kind;
      logic [CFG_W-1:0]  frames;
      logic [PAGE_W-1:0] page;
      logic              last;
      bit                typed;
      rsp_type           want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PAGE_W-1:0]  req_page = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_fault;
   logic [SLOT_W-1:0]  rsp_frame_slot;
   logic               rsp_evicted_valid;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [COUNT_W-1:0] rsp_fault_count;
   logic               rsp_done_res;
   logic               csr_wr_en = 1'b0;
   logic [CFG_W-1:0]   csr_wr_data = '0;

   // Typed expectation that travels with the reference being offered.
   bit                 drv_typed = 1'b0;
   rsp_type            drv_want = '0;

   // Idling controls shared by the sender, the receiver and the sequencer.
   bit                 no_idle = 1'b0;
   bit                 hold_req = 1'b0;

   // Own copy of the frame table and the register.
   logic [PAGE_W-1:0]  resident_page [FRAMES];
   bit                 resident_valid [FRAMES];
   int unsigned        resident_rank [FRAMES];
   logic [COUNT_W-1:0] fault_tally;
   logic [CFG_W-1:0]   managed_cfg;

   rsp_type            pending_results [$];

   int                 fail_count = 0;
   int                 cycle_count = 0;
   int                 hit_total = 0;
   int                 fault_total = 0;
   int                 evict_total = 0;
   int                 sequence_total = 0;
   int                 cfg_write_total = 0;
   bit                 counter_saturated = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page          (req_page),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fault         (rsp_fault),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .rsp_done_res      (rsp_done_res),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Zero acts as one frame, anything above the built count as all frames.
   function automatic int managed_count(logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > FRAMES) return FRAMES;
      return int'(value);
   endfunction

   function automatic void clear_residency();
      for (int j = 0; j < FRAMES; j++) begin
         resident_page[j]  = '0;
         resident_valid[j] = 1'b0;
         resident_rank[j]  = 0;
      end
      fault_tally = '0;
   endfunction

   // Looks the page up in the managed frames, updates recency and returns
   // the result the block should report for this reference.
   function automatic rsp_type lru_lookup(logic [PAGE_W-1:0] page, logic last);
      int          n;
      int          slot;
      int unsigned worst;
      int unsigned limit;
      bit          hit;
      bit          found;
      rsp_type     r;
      n     = managed_count(managed_cfg);
      slot  = 0;
      hit   = 1'b0;
      found = 1'b0;
      r     = '0;
      for (int j = 0; j < n && !hit; j++) begin
         if (resident_valid[j] && resident_page[j] == page) begin
            hit  = 1'b1;
            slot = j;
         end
      end
      if (hit) begin
         // Frames more recent than the hit one each move back by one.
         limit = resident_rank[slot];
         for (int j = 0; j < n; j++) begin
            if (resident_valid[j] && resident_rank[j] < limit) resident_rank[j]++;
         end
         resident_rank[slot] = 0;
      end else begin
         for (int j = 0; j < n && !found; j++) begin
            if (!resident_valid[j]) begin
               slot  = j;
               found = 1'b1;
            end
         end
         // No free frame: the lowest frame with the oldest rank goes.
         if (!found) begin
            worst = 0;
            slot  = 0;
            for (int j = 0; j < n; j++) begin
               if (resident_rank[j] > worst) begin
                  worst = resident_rank[j];
                  slot  = j;
               end
            end
            r.evicted_valid      = 1'b1;
            r.evicted_page       = resident_page[slot];
            resident_valid[slot] = 1'b0;
         end
         for (int j = 0; j < n; j++) begin
            if (resident_valid[j] && resident_rank[j] < FRAMES) resident_rank[j]++;
         end
         resident_page[slot]  = page;
         resident_valid[slot] = 1'b1;
         resident_rank[slot]  = 0;
         if (fault_tally != COUNT_MAX) fault_tally++;
      end
      r.fault       = !hit;
      r.frame_slot  = slot[SLOT_W-1:0];
      r.fault_count = fault_tally;
      r.done_res    = last;
      if (last) clear_residency();
      return r;
   endfunction

   // Watch every edge: check result transfers, track register writes and
   // predict each request transfer, all from values sampled before the edge.
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      rsp_type predicted;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("lru_page_replacement verification failed");
         $finish;
      end else if (reset) begin
         clear_residency();
         managed_cfg = CFG_RESET[CFG_W-1:0];
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_fault, rsp_frame_slot, rsp_evicted_valid, rsp_evicted_page,
                   rsp_fault_count, rsp_done_res};
            if (pending_results.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("cycle %0d: result transfer with nothing expected", cycle_count);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.fault !== want.fault || got.frame_slot !== want.frame_slot ||
                   got.evicted_valid !== want.evicted_valid ||
                   got.evicted_page !== want.evicted_page ||
                   got.fault_count !== want.fault_count ||
                   got.done_res !== want.done_res) begin
                  if (fail_count < REPORT_LIMIT) begin
                     $display({"cycle %0d: expected fault=%0d slot=%0d evict=%0d/%h",
                               " count=%0d last=%0d"},
                              cycle_count, want.fault, want.frame_slot, want.evicted_valid,
                              want.evicted_page, want.fault_count, want.done_res);
                     $display({"cycle %0d:   actual fault=%0d slot=%0d evict=%0d/%h",
                               " count=%0d last=%0d"},
                              cycle_count, got.fault, got.frame_slot, got.evicted_valid,
                              got.evicted_page, got.fault_count, got.done_res);
                  end
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            managed_cfg = csr_wr_data;
            clear_residency();
            cfg_write_total++;
         end
         if (req_valid && !req_stall) begin
            predicted = lru_lookup(req_page, req_last);
            pending_results.push_back(drv_typed ? drv_want : predicted);
            if (predicted.fault) fault_total++;
            else hit_total++;
            if (predicted.evicted_valid) evict_total++;
            if (predicted.done_res) sequence_total++;
            if (predicted.fault_count == COUNT_MAX) counter_saturated = 1'b1;
         end
      end
   end

   // Receiver: random stall bursts, one long hold when asked, none when quiet.
   initial begin
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // Offers one reference, possibly after an idle burst, and returns at the
   // edge of its transfer with valid still high.
   task automatic offer_ref(logic [PAGE_W-1:0] page, logic last, bit typed, rsp_type want);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page  <= page;
      req_last  <= last;
      drv_typed <= typed;
      drv_want  <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Writes the frame count once every outstanding result has come back.
   task automatic write_frames(logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic stim_row_type cfg_row(logic [CFG_W-1:0] value);
      stim_row_type row;
      row = '{kind: ROW_CFG, frames: value, page: '0, last: 1'b0, typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic stim_row_type ref_row(logic [PAGE_W-1:0] page, logic last);
      stim_row_type row;
      row = '{kind: ROW_REF, frames: '0, page: page, last: last, typed: 1'b0, want: '0};
      return row;
   endfunction

   function automatic stim_row_type checked_row(logic [PAGE_W-1:0] page, logic last,
                                                logic fault, logic [SLOT_W-1:0] slot,
                                                logic evicted,
                                                logic [PAGE_W-1:0] evicted_page,
                                                logic [COUNT_W-1:0] count);
      stim_row_type row;
      row = ref_row(page, last);
      row.typed = 1'b1;
      row.want  = {fault, slot, evicted, evicted_page, count, last};
      return row;
   endfunction

   initial begin : stimulus
      stim_row_type      directed_rows [$];
      logic [CFG_W-1:0]  phase_cfg [PHASES];
      logic [PAGE_W-1:0] working_set [12];
      logic [PAGE_W-1:0] page;
      int                per_phase;
      int                sent;
      int                eff;
      int                set_size;
      int                run_len;
      bit                broken;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table. After reset three frames are managed.
      directed_rows.push_back(checked_row(16'h0000, 1'b0, 1'b1, 3'd0, 1'b0, 16'h0000, 16'd1));
      directed_rows.push_back(checked_row(16'hFFFF, 1'b0, 1'b1, 3'd1, 1'b0, 16'h0000, 16'd2));
      directed_rows.push_back(checked_row(16'h0000, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd2));
      directed_rows.push_back(checked_row(16'h5555, 1'b0, 1'b1, 3'd2, 1'b0, 16'h0000, 16'd3));
      // All three full: the least recent page FFFF leaves frame 1.
      directed_rows.push_back(checked_row(16'hAAAA, 1'b0, 1'b1, 3'd1, 1'b1, 16'hFFFF, 16'd4));
      directed_rows.push_back(checked_row(16'h0000, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd4));
      // The last flag emptied the frames and the count.
      directed_rows.push_back(checked_row(16'hFFFF, 1'b0, 1'b1, 3'd0, 1'b0, 16'h0000, 16'd1));
      // A zero frame count manages a single frame, and the write clears state.
      directed_rows.push_back(cfg_row(4'd0));
      directed_rows.push_back(checked_row(16'h1234, 1'b0, 1'b1, 3'd0, 1'b0, 16'h0000, 16'd1));
      directed_rows.push_back(checked_row(16'h1234, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 16'd1));
      directed_rows.push_back(checked_row(16'h4321, 1'b0, 1'b1, 3'd0, 1'b1, 16'h1234, 16'd2));
      // An oversized frame count manages all eight frames.
      directed_rows.push_back(cfg_row(4'd15));
      for (int p = 1; p <= 9; p++) directed_rows.push_back(ref_row(PAGE_W'(p), 1'b0));
      directed_rows.push_back(ref_row(16'h0002, 1'b1));
      directed_rows.push_back(cfg_row(4'd8));
      directed_rows.push_back(ref_row(16'h8001, 1'b0));
      directed_rows.push_back(ref_row(16'h7FFE, 1'b1));

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CFG) write_frames(directed_rows[r].frames);
         else offer_ref(directed_rows[r].page, directed_rows[r].last,
                        directed_rows[r].typed, directed_rows[r].want);
      end

      // Random phases, each with its own frame count.
      phase_cfg = '{4'd15, 4'd0, 4'd1, 4'd8, 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 4'd2, 4'($urandom_range(1, 8))};
      per_phase = RANDOM_REFS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         write_frames(phase_cfg[ph]);
         if (ph == PHASES - 1) no_idle = 1'b1;
         // Hold results back long enough for the output stage to fill.
         if (ph == 0 || ph == 3) hold_req = 1'b1;
         eff  = managed_count(phase_cfg[ph]);
         sent = 0;
         while (sent < per_phase) begin
            // A sequence works over a set of pages near the frame count, so
            // hits, fills and evictions all occur; a few stray pages and
            // sequences left open add noise.
            set_size = (eff > 1 ? eff - 1 : 1) + $urandom_range(0, 4);
            for (int k = 0; k < set_size; k++)
               working_set[k] = PAGE_W'($urandom_range(0, 65535));
            run_len = $urandom_range(1, 40);
            broken  = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(0, 6) == 0) page = PAGE_W'($urandom_range(0, 65535));
               else page = working_set[$urandom_range(0, set_size - 1)];
               offer_ref(page, (i == run_len - 1) && !broken, 1'b0, '0);
               sent++;
            end
         end
      end

      // Drain, then give the block a few quiet cycles.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d hits, %0d faults, %0d evictions over %0d closed sequences.",
               hit_total, fault_total, evict_total, sequence_total);
      $display("Frame count written %0d times; fault count saturation reached: %0d.",
               cfg_write_total, counter_saturated);
      if (fail_count == 0) begin
         $display("lru_page_replacement verification clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("lru_page_replacement verification failed");
      end
      $finish;
   end

endmodule
